@@ sv/orgu_pkg.sv @@
package orgu_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  order_kind;
        logic [31:0] user_ref;
        logic [63:0] symbol_code;
        logic        symbol_present;
        logic [31:0] order_quantity;
        logic [31:0] order_price;
    } request_t;

    typedef struct packed {
        logic        decision;
        logic [3:0]  deny_code;
        logic [1:0]  kind_echo;
        logic [31:0] user_ref_echo;
        logic [31:0] quantity_echo;
        logic [31:0] price_echo;
        logic [63:0] notional;
        logic        table_full;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic req_clear;
        logic scan_last;
    } dp_status_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_QTY        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_NOTIONAL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_HALT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CXL_MODE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ON     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_QTY_CEILING    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRICE_CEILING  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_CANCEL_CEILING = 3'd7;

    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_ENABLE  = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] KIND_ENTER   = 2'd0;
    localparam logic [1:0] KIND_REPLACE = 2'd1;
    localparam logic [1:0] KIND_CANCEL  = 2'd2;

    localparam logic [3:0] RSN_NONE        = 4'd0;
    localparam logic [3:0] RSN_HALT        = 4'd1;
    localparam logic [3:0] RSN_CXL_MODE    = 4'd2;
    localparam logic [3:0] RSN_QUANTITY    = 4'd3;
    localparam logic [3:0] RSN_PRICE       = 4'd4;
    localparam logic [3:0] RSN_NO_SYMBOL   = 4'd5;
    localparam logic [3:0] RSN_DISABLED    = 4'd6;
    localparam logic [3:0] RSN_MAX_QTY     = 4'd7;
    localparam logic [3:0] RSN_MAX_NOTION  = 4'd8;

    localparam logic [31:0] RST_QTY_CEILING    = 32'd999999;
    localparam logic [31:0] RST_PRICE_CEILING  = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_CANCEL_CEILING = 32'd999999;

endpackage

@@ sv/orgu_ctrl.sv @@
module orgu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  orgu_pkg::dp_status_t status,
    output orgu_pkg::dp_cmd_t    cmd,
    output logic                busy
);
    import orgu_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = status.req_clear ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:   cmd.scan = 1'b1;
            ST_DRAIN:  cmd = '0;
            ST_FINISH: cmd.finish = 1'b1;
            default:   cmd = '0;
        endcase
    end

    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish && !busy)
        else $error("finish not followed by idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy && start)
        else $error("load while busy");
    a_drain_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> cmd.finish)
        else $error("drain not followed by finish");

endmodule

@@ sv/orgu_datapath.sv @@
module orgu_datapath #(
    parameter int SYMBOL_SLOTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  orgu_pkg::request_t                   request,
    input  orgu_pkg::dp_cmd_t                    cmd,
    output orgu_pkg::dp_status_t                 status,
    input  logic                                 cfg_we,
    input  logic [orgu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [orgu_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 done,
    output orgu_pkg::result_t                    result
);
    import orgu_pkg::*;

    localparam int IDX_W = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_SLOTS - 1);

    logic [31:0] max_qty_reg;
    logic [63:0] max_notional_reg;
    logic        halt_reg;
    logic        cxl_mode_reg;
    logic        default_on_reg;
    logic [31:0] qty_ceiling_reg;
    logic [31:0] price_ceiling_reg;
    logic [31:0] cancel_ceiling_reg;

    request_t    req_reg;
    logic [63:0] prod_reg;
    logic        done_reg;
    result_t     result_reg;

    logic [63:0]             sym_mem [SYMBOL_SLOTS];
    logic [63:0]             rd_data_reg;
    logic [SYMBOL_SLOTS-1:0] valid_reg;
    logic [SYMBOL_SLOTS-1:0] enabled_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_pending_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic             found_en_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic             hit;
    logic             empty_slot;
    logic             cxl_kind;
    logic             need_sym;
    logic             sym_on;
    logic [3:0]       reason;
    logic [63:0]      notional_val;
    logic             tbl_op;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             full;

    assign status.req_clear = (request.operation == OP_CLEAR);
    assign status.scan_last = (scan_idx_reg == LAST_IDX);

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_qty_reg        <= '0;
            max_notional_reg   <= '0;
            halt_reg           <= 1'b0;
            cxl_mode_reg       <= 1'b0;
            default_on_reg     <= 1'b1;
            qty_ceiling_reg    <= RST_QTY_CEILING;
            price_ceiling_reg  <= RST_PRICE_CEILING;
            cancel_ceiling_reg <= RST_CANCEL_CEILING;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_QTY:        max_qty_reg        <= cfg_data[31:0];
                CFG_MAX_NOTIONAL:   max_notional_reg   <= cfg_data;
                CFG_GLOBAL_HALT:    halt_reg           <= cfg_data[0];
                CFG_CXL_MODE:       cxl_mode_reg       <= cfg_data[0];
                CFG_DEFAULT_ON:     default_on_reg     <= cfg_data[0];
                CFG_QTY_CEILING:    qty_ceiling_reg    <= cfg_data[31:0];
                CFG_PRICE_CEILING:  price_ceiling_reg  <= cfg_data[31:0];
                CFG_CANCEL_CEILING: cancel_ceiling_reg <= cfg_data[31:0];
                default:            max_qty_reg        <= max_qty_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        prod_reg    <= {32'd0, req_reg.order_quantity} * {32'd0, req_reg.order_price};
        rd_data_reg <= sym_mem[scan_idx_reg];
        if (wr_en)
        begin
            sym_mem[wr_idx] <= req_reg.symbol_code;
        end
    end

    assign hit        = rd_pending_reg && valid_reg[rd_idx_reg]
                        && (rd_data_reg == req_reg.symbol_code);
    assign empty_slot = rd_pending_reg && !valid_reg[rd_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            rd_idx_reg     <= '0;
            rd_pending_reg <= 1'b0;
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
            found_en_reg   <= 1'b0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            rd_pending_reg <= cmd.scan;
            rd_idx_reg     <= scan_idx_reg;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
                free_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (hit && !found_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= rd_idx_reg;
                    found_en_reg  <= enabled_reg[rd_idx_reg];
                end
                if (empty_slot && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end
        end
    end

    assign cxl_kind  = (req_reg.order_kind == KIND_CANCEL);
    assign need_sym  = (req_reg.order_kind == KIND_ENTER)
                       || (req_reg.order_kind == KIND_REPLACE);
    assign sym_on    = found_reg ? found_en_reg : default_on_reg;
    assign tbl_op    = (req_reg.operation == OP_ENABLE) || (req_reg.operation == OP_DISABLE);
    assign full      = tbl_op && !found_reg && !free_reg;
    assign wr_en     = cmd.finish && tbl_op && !full;
    assign wr_idx    = found_reg ? found_idx_reg : free_idx_reg;

    always_comb
    begin
        reason       = RSN_NONE;
        notional_val = '0;
        if (req_reg.operation == OP_CHECK)
        begin
            priority if (halt_reg)
                reason = RSN_HALT;
            else if (cxl_mode_reg && !cxl_kind)
                reason = RSN_CXL_MODE;
            else if (cxl_kind)
            begin
                if (req_reg.order_quantity > cancel_ceiling_reg)
                    reason = RSN_QUANTITY;
            end
            else if (req_reg.order_quantity == 32'd0
                     || req_reg.order_quantity > qty_ceiling_reg)
                reason = RSN_QUANTITY;
            else if (req_reg.order_price > price_ceiling_reg)
                reason = RSN_PRICE;
            else if (need_sym && !req_reg.symbol_present)
                reason = RSN_NO_SYMBOL;
            else if (req_reg.symbol_present && !sym_on)
                reason = RSN_DISABLED;
            else if (req_reg.order_quantity > max_qty_reg)
                reason = RSN_MAX_QTY;
            else if (prod_reg > max_notional_reg)
            begin
                reason       = RSN_MAX_NOTION;
                notional_val = prod_reg;
            end
            else
                notional_val = prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            enabled_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish && req_reg.operation == OP_CLEAR)
            begin
                valid_reg   <= '0;
                enabled_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_idx]   <= 1'b1;
                enabled_reg[wr_idx] <= (req_reg.operation == OP_ENABLE);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.decision      <= (reason != RSN_NONE);
            result_reg.deny_code     <= reason;
            result_reg.kind_echo     <= req_reg.order_kind;
            result_reg.user_ref_echo <= req_reg.user_ref;
            result_reg.quantity_echo <= req_reg.order_quantity;
            result_reg.price_echo    <= req_reg.order_price;
            result_reg.notional      <= notional_val;
            result_reg.table_full    <= full;
        end
    end

    a_done_follows_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.finish))
        else $error("strobe without finish");
    a_no_read_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !rd_pending_reg)
        else $error("scan still in flight at finish");
    a_full_is_table_op: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (!result.decision && result.notional == 64'd0))
        else $error("table_full on a check request");

endmodule

@@ sv/order_risk_guardrail_unit.sv @@
// channel   signals                              handshake
// request   start, busy, request                 taken when start && !busy
// result    done, result                         valid for the one cycle done is high
// config    cfg_we, cfg_index, cfg_data          written when cfg_we is high
//
// Check, enable and disable requests scan the symbol table, one entry a cycle
// through its single read port, then pass the drain and finish states to done.
// Clear requests skip the scan. A new request may start the cycle done is high.
// Reset clears the override table valid bits at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module order_risk_guardrail_unit #(
    parameter int SYMBOL_SLOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  orgu_pkg::request_t               request,
    output logic                             done,
    output orgu_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [orgu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [orgu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import orgu_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    orgu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    orgu_datapath #(
        .SYMBOL_SLOTS (SYMBOL_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule
